### rtl/iedet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Isolated emoji detector package
// Shared widths, code point constants, register indexes and the character
// class record passed from the classifier to the parser.
// ----------------------------------------------------------------------------
package iedet_pkg;

   // Most emoji sequences accepted in one message.
   localparam int MAX_TOKENS = 3;
   localparam int CNT_W      = $clog2(MAX_TOKENS + 1);

   localparam int CP_W    = 21;
   localparam int COUNT_W = 2;
   localparam int ROW_W   = 11;
   localparam int PX_W    = 8;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_PX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_PX  = 2'd2;

   localparam logic            RST_ENABLE  = 1'b1;
   localparam logic [PX_W-1:0] RST_CELL_PX = 8'd38;
   localparam logic [PX_W-1:0] RST_GAP_PX  = 8'd2;

   // Code points with a role of their own in a sequence.
   localparam logic [CP_W-1:0] CP_VS15      = 21'h00FE0E;
   localparam logic [CP_W-1:0] CP_VS16      = 21'h00FE0F;
   localparam logic [CP_W-1:0] CP_KEYCAP    = 21'h0020E3;
   localparam logic [CP_W-1:0] CP_ZWJ       = 21'h00200D;
   localparam logic [CP_W-1:0] CP_RI_LO     = 21'h01F1E0;
   localparam logic [CP_W-1:0] CP_RI_HI     = 21'h01F1FF;
   localparam logic [CP_W-1:0] CP_TAG_LO    = 21'h0E0020;
   localparam logic [CP_W-1:0] CP_TAG_HI    = 21'h0E007F;
   localparam logic [CP_W-1:0] CP_SKIN_LO   = 21'h01F3FB;
   localparam logic [CP_W-1:0] CP_SKIN_HI   = 21'h01F3FF;
   localparam logic [CP_W-1:0] CP_HASH      = 21'h000023;
   localparam logic [CP_W-1:0] CP_ASTERISK  = 21'h00002A;

   // Character classes of one code point; several may be set at once.
   typedef struct packed {
      logic space;
      logic keycap_base;
      logic emoji_base;
      logic flag_letter;
      logic modifier;
      logic vs16;
      logic keycap;
      logic zwj;
   } class_type;

endpackage : iedet_pkg
`default_nettype wire

### rtl/iedet_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Isolated emoji detector channels
// Valid/ready channels for the code point stream and for the per-message
// result.
// ----------------------------------------------------------------------------
interface iedet_req_if;
   import iedet_pkg::*;

   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            char_present;
   logic            last;

   modport source (output valid, code_point, char_present, last, input ready);
   modport sink   (input valid, code_point, char_present, last, output ready);
endinterface : iedet_req_if

interface iedet_rsp_if;
   import iedet_pkg::*;

   logic               valid;
   logic               ready;
   logic               large_emoji;
   logic [COUNT_W-1:0] emoji_count;
   logic [ROW_W-1:0]   row_width_px;

   modport source (output valid, large_emoji, emoji_count, row_width_px, input ready);
   modport sink   (input valid, large_emoji, emoji_count, row_width_px, output ready);
endinterface : iedet_rsp_if
`default_nettype wire

### rtl/iedet_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Isolated emoji detector character classifier
// Range compares that sort one code point into the classes the parser uses.
// ----------------------------------------------------------------------------
module iedet_classify (
   input  wire logic [iedet_pkg::CP_W-1:0] code_point,
   output iedet_pkg::class_type            char_class
);
   import iedet_pkg::*;

   logic [CP_W-1:0] c;
   logic            is_tag;
   logic            is_ri;

   assign c = code_point;

   always_comb begin
      is_tag = (c >= CP_TAG_LO) && (c <= CP_TAG_HI);
      is_ri  = (c >= CP_RI_LO) && (c <= CP_RI_HI);

      char_class.space =
         ((c >= 21'h09) && (c <= 21'h0D)) || (c == 21'h20) || (c == 21'h85) ||
         (c == 21'hA0) || (c == 21'h1680) || ((c >= 21'h2000) && (c <= 21'h200A)) ||
         (c == 21'h2028) || (c == 21'h2029) || (c == 21'h202F) ||
         (c == 21'h205F) || (c == 21'h3000);

      char_class.keycap_base =
         (c == CP_HASH) || (c == CP_ASTERISK) || ((c >= 21'h30) && (c <= 21'h39));

      char_class.emoji_base =
         (c == 21'hA9) || (c == 21'hAE) || (c == 21'h203C) || (c == 21'h2049) ||
         ((c >= 21'h2122) && (c <= 21'h2199)) || ((c >= 21'h2300) && (c <= 21'h23FF)) ||
         ((c >= 21'h2460) && (c <= 21'h24FF)) || ((c >= 21'h25A0) && (c <= 21'h27BF)) ||
         ((c >= 21'h2934) && (c <= 21'h2935)) || ((c >= 21'h2B05) && (c <= 21'h2B07)) ||
         ((c >= 21'h2B1B) && (c <= 21'h2B1C)) || (c == 21'h2B50) || (c == 21'h2B55) ||
         (c == 21'h3030) || (c == 21'h303D) || (c == 21'h3297) || (c == 21'h3299) ||
         (c == 21'h1F004) || (c == 21'h1F0CF) ||
         ((c >= 21'h1F1E0) && (c <= 21'h1F64F)) ||
         ((c >= 21'h1F680) && (c <= 21'h1F6FF)) ||
         ((c >= 21'h1F900) && (c <= 21'h1FAFF)) || is_tag;

      char_class.flag_letter = is_ri;
      char_class.vs16        = (c == CP_VS16);
      char_class.keycap      = (c == CP_KEYCAP);
      char_class.zwj         = (c == CP_ZWJ);
      char_class.modifier    =
         (c == CP_VS15) || (c == CP_VS16) || (c == CP_KEYCAP) || is_tag ||
         ((c >= CP_SKIN_LO) && (c <= CP_SKIN_HI));
   end

endmodule : iedet_classify
`default_nettype wire

### rtl/isolated_emoji_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Isolated emoji detector
// Parses a message one code point per beat and, on the last beat, reports
// whether it is one to three emoji, with or without whitespace between, and its row width.
// ----------------------------------------------------------------------------
// Throughput: one request beat per cycle, sustained. Only a last beat waits,
//   and only while the previous result is still held in the result register.
// Result path: the input register loads when the last beat is accepted,
//   then the result register loads once it is free, and the result is
//   held there until taken.
// Reset: synchronous, active high; clears both pipeline valids, the parser
//   state and restores enable = 1, cell_px = 38, gap_px = 2.
// ----------------------------------------------------------------------------
module isolated_emoji_detector_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   iedet_req_if.sink                             req_bus,
   iedet_rsp_if.source                           rsp_bus,
   input  wire logic                             csr_we,
   input  wire logic [iedet_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [iedet_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import iedet_pkg::*;

   // Parser phases. A token is one emoji sequence.
   typedef enum logic [2:0] {
      PH_IDLE,   // between tokens
      PH_KEY1,   // after a keycap base
      PH_KEY2,   // after a keycap base and FE0F
      PH_SEQ,    // inside an emoji sequence
      PH_JOIN,   // after a joiner, waiting for the linked base
      PH_FAIL    // message already failed
   } phase_type;

   // Configuration registers.
   logic            enable_ff;
   logic [PX_W-1:0] cell_px_ff;
   logic [PX_W-1:0] gap_px_ff;

   // Input register stage.
   logic            s1_valid_ff;
   logic [CP_W-1:0] s1_code_ff;
   logic            s1_present_ff;
   logic            s1_last_ff;

   // Parser state.
   phase_type       phase_ff,  phase_in;
   logic            flag_ff,   flag_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Result register.
   logic               rsp_valid_ff;
   logic               large_emoji_ff,  large_emoji_in;
   logic [COUNT_W-1:0] emoji_count_ff,  emoji_count_in;
   logic [ROW_W-1:0]   row_width_ff,    row_width_in;

   class_type  cls;
   logic       out_free;
   logic       s1_go;

   // Intermediate values of the parser step.
   phase_type        start_phase;
   logic             start_flag;
   logic [CNT_W-1:0] start_count;
   phase_type        char_phase;
   logic             char_flag;
   logic [CNT_W-1:0] char_count;
   logic             msg_ok;
   logic [CNT_W+PX_W:0] cell_sum;
   logic [CNT_W+PX_W:0] gap_sum;

   // ------------------------------------------------------------------------
   // Configuration writes. Indexes beyond the register list are dropped.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= RST_ENABLE;
         cell_px_ff <= RST_CELL_PX;
         gap_px_ff  <= RST_GAP_PX;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:  enable_ff  <= csr_wdata[0];
            CSR_CELL_PX: cell_px_ff <= csr_wdata[PX_W-1:0];
            CSR_GAP_PX:  gap_px_ff  <= csr_wdata[PX_W-1:0];
            default:     ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Flow control. A non-last beat only updates the parser, so it moves on
   // at once. A last beat needs the result register, which must be empty or
   // being drained this cycle. The input register refills in the same cycle
   // it empties, which gives full rate.
   // ------------------------------------------------------------------------
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_go         = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         s1_code_ff    <= req_bus.code_point;
         s1_present_ff <= req_bus.char_present;
         s1_last_ff    <= req_bus.last;
      end
   end

   iedet_classify u_classify (
      .code_point (s1_code_ff),
      .char_class (cls)
   );

   // ------------------------------------------------------------------------
   // Parser step. start_* is what happens when the character may open a new
   // token: whitespace keeps us between tokens, a fourth token fails the
   // message, a keycap or emoji base opens a token, and anything else fails.
   // ------------------------------------------------------------------------
   always_comb begin
      start_phase = PH_FAIL;
      start_flag  = flag_ff;
      start_count = count_ff;
      if (cls.space) begin
         start_phase = PH_IDLE;
      end else if (count_ff >= CNT_W'(MAX_TOKENS)) begin
         start_phase = PH_FAIL;
      end else if (cls.keycap_base) begin
         start_phase = PH_KEY1;
         start_count = count_ff + CNT_W'(1);
      end else if (cls.emoji_base) begin
         start_phase = PH_SEQ;
         start_flag  = cls.flag_letter;
         start_count = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      char_phase = phase_ff;
      char_flag  = flag_ff;
      char_count = count_ff;
      if (s1_present_ff) begin
         unique case (phase_ff)
            PH_IDLE: begin
               char_phase = start_phase;
               char_flag  = start_flag;
               char_count = start_count;
            end
            PH_KEY1: begin
               if (cls.vs16) begin
                  char_phase = PH_KEY2;
               end else if (cls.keycap) begin
                  char_phase = PH_IDLE;
               end else begin
                  char_phase = PH_FAIL;
               end
            end
            PH_KEY2: begin
               char_phase = cls.keycap ? PH_IDLE : PH_FAIL;
            end
            PH_SEQ: begin
               // Modifiers and, after a flag base, further regional
               // indicators extend the current token.
               if (cls.modifier || (flag_ff && cls.flag_letter)) begin
                  char_phase = PH_SEQ;
               end else if (cls.zwj) begin
                  char_phase = PH_JOIN;
               end else begin
                  char_phase = start_phase;
                  char_flag  = start_flag;
                  char_count = start_count;
               end
            end
            PH_JOIN: begin
               char_phase = cls.emoji_base ? PH_SEQ : PH_FAIL;
            end
            default: begin
               char_phase = PH_FAIL;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Result. A message is good when it ends between tokens or inside a
   // sequence, with at least one token. The width is count cells plus
   // count - 1 gaps; both are masked to the field widths.
   // ------------------------------------------------------------------------
   always_comb begin
      msg_ok   = ((char_phase == PH_IDLE) || (char_phase == PH_SEQ)) &&
                 (char_count != '0);
      cell_sum = (CNT_W+PX_W+1)'(char_count) * (CNT_W+PX_W+1)'(cell_px_ff);
      gap_sum  = (CNT_W+PX_W+1)'(char_count - CNT_W'(1)) *
                 (CNT_W+PX_W+1)'(gap_px_ff);

      large_emoji_in = msg_ok && enable_ff;
      emoji_count_in = msg_ok ? COUNT_W'(char_count) : '0;
      row_width_in   = msg_ok ? ROW_W'(cell_sum + gap_sum) : '0;

      // The last beat returns the parser to its reset state.
      if (s1_last_ff) begin
         phase_in = PH_IDLE;
         flag_in  = 1'b0;
         count_in = '0;
      end else begin
         phase_in = char_phase;
         flag_in  = char_flag;
         count_in = char_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         flag_ff  <= 1'b0;
         count_ff <= '0;
      end else if (s1_go) begin
         phase_ff <= phase_in;
         flag_ff  <= flag_in;
         count_ff <= count_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result register. It loads on a last beat and holds until taken.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_last_ff) begin
         large_emoji_ff <= large_emoji_in;
         emoji_count_ff <= emoji_count_in;
         row_width_ff   <= row_width_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.large_emoji  = large_emoji_ff;
   assign rsp_bus.emoji_count  = emoji_count_ff;
   assign rsp_bus.row_width_px = row_width_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_go && s1_last_ff))
      else $error("result appeared without a last beat");

   a_parser_cleared: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(s1_go && s1_last_ff)) |->
         (phase_ff == PH_IDLE && count_ff == '0 && !flag_ff))
      else $error("parser state not cleared after a last beat");

   a_large_has_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && large_emoji_ff) |-> (emoji_count_ff != '0))
      else $error("large emoji flagged with zero count");

   a_zero_count_zero_width: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && emoji_count_ff == '0) |-> (row_width_ff == '0))
      else $error("nonzero width for an invalid message");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (count_ff <= CNT_W'(MAX_TOKENS)))
      else $error("token count beyond the limit");

endmodule : isolated_emoji_detector_top
`default_nettype wire
